// ----- sv/gpio_prb_pkg.sv -----
package gpio_prb_pkg;

  // Item function codes
  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_PIN   = 2'd2;
  localparam logic [1:0] FUNC_ALT   = 2'd3;

  // Register word indexes
  localparam logic [7:0] ADDR_MODE  = 8'd0;
  localparam logic [7:0] ADDR_OTYPE = 8'd1;
  localparam logic [7:0] ADDR_SPEED = 8'd2;
  localparam logic [7:0] ADDR_PULL  = 8'd3;
  localparam logic [7:0] ADDR_IDR   = 8'd4;
  localparam logic [7:0] ADDR_ODR   = 8'd5;
  localparam logic [7:0] ADDR_BSRR  = 8'd6;
  localparam logic [7:0] ADDR_LOCK  = 8'd7;
  localparam logic [7:0] ADDR_AFL   = 8'd8;
  localparam logic [7:0] ADDR_AFH   = 8'd9;

  // Pin mode field codes
  localparam logic [1:0] MODE_INPUT  = 2'd0;
  localparam logic [1:0] MODE_OUTPUT = 2'd1;
  localparam logic [1:0] MODE_ALT    = 2'd2;
  localparam logic [1:0] MODE_ANALOG = 2'd3;

  // Pull field codes that allow a high level
  localparam logic [1:0] PULL_NONE = 2'd0;
  localparam logic [1:0] PULL_UP   = 2'd1;

  // Resolved direction codes
  localparam logic [1:0] DIR_INPUT  = 2'd0;
  localparam logic [1:0] DIR_OUTPUT = 2'd1;
  localparam logic [1:0] DIR_HIZ    = 2'd2;

  localparam int unsigned LOCK_HIST_W = 17;  // key bit plus 16 key value bits
  localparam int unsigned LOCK_KEY_BIT = 16;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  addr;
    logic [31:0] wdata;
    logic [3:0]  pin_index;
    logic        pin_level;
    logic [15:0] af_levels;
  } gpio_prb_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [31:0] pin_direction;
    logic [15:0] pin_high;
    logic [15:0] pin_drive;
    logic [15:0] changed_pins;
    logic        locked;
  } gpio_prb_out_t;

  typedef logic [15:0] gpio_prb_cfg_t;

endpackage

// ----- sv/gpio_port_register_block.sv -----
// GPIO port register block. Each item is a bus read, a bus write, an external
// pin level event or an update of the per-pin alternate-function levels, and
// each item gives exactly one result item. Throughput is one item per clock
// while the output register is taken: an accepted item lands in an input
// register, a single pass of logic then updates the port registers and
// resolves the affected pins in parallel, and the result is captured in the
// output register. Both stages stall only when the output register is full
// and not taken. The external circuit mask is written on a separate
// always-ready config channel and must only be written while no item is in
// flight. Once the lock key sequence (key bit 1, 0, 1 with equal low halves)
// has been written to the lock word, all bus writes are dropped until reset.
module gpio_port_register_block
  import gpio_prb_pkg::*;
#(
  parameter int unsigned PIN_COUNT = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  gpio_prb_in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output gpio_prb_out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  gpio_prb_cfg_t cfg_data_i
);

  localparam int unsigned PIN_W = $clog2(PIN_COUNT);
  localparam logic [PIN_COUNT-1:0] PIN_ALL = {PIN_COUNT{1'b1}};

  // Handshake / pipeline control
  logic          s1_valid_q;
  gpio_prb_in_t  s1_q;
  logic          out_valid_q;
  gpio_prb_out_t out_q, out_d;
  logic          advance;

  // Architectural state
  logic [31:0] mode_q, mode_d, otype_q, otype_d, speed_q, speed_d, pull_q, pull_d;
  logic [31:0] odr_q, odr_d, afl_q, afl_d, afh_q, afh_d;
  logic [PIN_COUNT-1:0] idr_q, idr_d;
  logic [PIN_COUNT-1:0] alt_q, alt_d;
  logic [PIN_COUNT-1:0] ext_q;
  logic [LOCK_HIST_W-1:0] hist_q [3];
  logic [LOCK_HIST_W-1:0] hist_d [3];
  logic lock_q, lock_d;

  // Resolved pin status
  logic [2*PIN_COUNT-1:0] dir_q, dir_d;
  logic [PIN_COUNT-1:0]   high_q, high_d, drive_q, drive_d;

  logic [PIN_COUNT-1:0] res_mask, changed;
  logic [31:0]          rd;
  logic                 reg_chg;

  assign advance     = !out_valid_q || out_ready_i;
  assign in_ready_o  = !s1_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    logic [1:0] pmode, ppull, pdir;
    logic       potype, plevel, phigh, pdrive, pull_ok;

    mode_d  = mode_q;
    otype_d = otype_q;
    speed_d = speed_q;
    pull_d  = pull_q;
    odr_d   = odr_q;
    afl_d   = afl_q;
    afh_d   = afh_q;
    idr_d   = idr_q;
    alt_d   = alt_q;
    hist_d  = hist_q;
    lock_d  = lock_q;
    dir_d   = dir_q;
    high_d  = high_q;
    drive_d = drive_q;
    res_mask = '0;
    changed  = '0;
    rd       = '0;

    unique case (s1_q.func)
      FUNC_READ: begin
        unique case (s1_q.addr)
          ADDR_MODE:  rd = mode_q;
          ADDR_OTYPE: rd = otype_q;
          ADDR_SPEED: rd = speed_q;
          ADDR_PULL:  rd = pull_q;
          ADDR_IDR:   rd = 32'(idr_q);
          ADDR_ODR:   rd = odr_q;
          ADDR_AFL:   rd = afl_q;
          ADDR_AFH:   rd = afh_q;
          default:    rd = '0;
        endcase
      end
      FUNC_WRITE: begin
        if (!lock_q) begin
          unique case (s1_q.addr)
            ADDR_MODE:  mode_d  = s1_q.wdata;
            ADDR_OTYPE: otype_d = s1_q.wdata;
            ADDR_SPEED: speed_d = s1_q.wdata;
            ADDR_PULL:  pull_d  = s1_q.wdata;
            ADDR_ODR:   odr_d   = s1_q.wdata;
            // reset half wins over set half
            ADDR_BSRR:  odr_d = (odr_q | {16'h0, s1_q.wdata[15:0]})
                                & ~{16'h0, s1_q.wdata[31:16]};
            ADDR_LOCK: begin
              hist_d[2] = hist_q[1];
              hist_d[1] = hist_q[0];
              hist_d[0] = s1_q.wdata[LOCK_HIST_W-1:0];
              if (hist_d[2][LOCK_KEY_BIT] && !hist_d[1][LOCK_KEY_BIT] &&
                  hist_d[0][LOCK_KEY_BIT] &&
                  hist_d[2][LOCK_KEY_BIT-1:0] == hist_d[1][LOCK_KEY_BIT-1:0] &&
                  hist_d[2][LOCK_KEY_BIT-1:0] == hist_d[0][LOCK_KEY_BIT-1:0]) begin
                lock_d = 1'b1;
              end
            end
            ADDR_AFL:   afl_d = s1_q.wdata;
            ADDR_AFH:   afh_d = s1_q.wdata;
            default:    ;
          endcase
        end
      end
      FUNC_PIN: begin
        if ({1'b0, s1_q.pin_index} < 5'(PIN_COUNT)) begin
          idr_d[s1_q.pin_index[PIN_W-1:0]] = s1_q.pin_level;
        end
      end
      default: begin
        // alternate levels: only pins whose level moved are resolved
        alt_d    = s1_q.af_levels[PIN_COUNT-1:0];
        res_mask = s1_q.af_levels[PIN_COUNT-1:0] ^ alt_q;
      end
    endcase

    // a mode, type, speed, pull, output or alternate-function register whose value really changed re-resolves every pin
    reg_chg = (mode_d != mode_q) || (otype_d != otype_q) || (speed_d != speed_q) ||
              (pull_d != pull_q) || (odr_d != odr_q) || (afl_d != afl_q) ||
              (afh_d != afh_q);
    if (reg_chg) begin
      res_mask = PIN_ALL;
    end

    for (int p = 0; p < PIN_COUNT; p++) begin
      pmode   = mode_d[2*p +: 2];
      ppull   = pull_d[2*p +: 2];
      potype  = otype_d[p];
      pull_ok = (ppull == PULL_NONE) || (ppull == PULL_UP);
      plevel  = 1'b0;
      phigh   = 1'b0;
      pdrive  = 1'b0;
      unique case (pmode)
        MODE_INPUT: begin
          pdir  = DIR_INPUT;
          phigh = pull_ok;
        end
        MODE_ANALOG: begin
          pdir = DIR_HIZ;
        end
        default: begin
          pdir   = DIR_OUTPUT;
          plevel = (pmode == MODE_OUTPUT) ? odr_d[p] : alt_d[p];
          if (plevel) begin
            phigh  = potype ? pull_ok : 1'b1;
            pdrive = !potype;
          end
        end
      endcase
      if (res_mask[p]) begin
        if (phigh && !ext_q[p]) begin
          idr_d[p] = 1'b1;
        end
        if (dir_q[2*p +: 2] != pdir || high_q[p] != phigh || drive_q[p] != pdrive) begin
          changed[p] = 1'b1;
        end
        dir_d[2*p +: 2] = pdir;
        high_d[p]       = phigh;
        drive_d[p]      = pdrive;
      end
    end

    out_d.read_data     = rd;
    out_d.pin_direction = 32'(dir_d);
    out_d.pin_high      = 16'(high_d);
    out_d.pin_drive     = 16'(drive_d);
    out_d.changed_pins  = 16'(changed);
    out_d.locked        = lock_d;
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= '0;
      otype_q     <= '0;
      speed_q     <= '0;
      pull_q      <= '0;
      odr_q       <= '0;
      afl_q       <= '0;
      afh_q       <= '0;
      idr_q       <= '0;
      alt_q       <= '0;
      ext_q       <= '0;
      hist_q[0]   <= '0;
      hist_q[1]   <= '0;
      hist_q[2]   <= '0;
      lock_q      <= 1'b0;
      dir_q       <= '0;
      high_q      <= '0;
      drive_q     <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
      if (cfg_valid_i) begin
        ext_q <= cfg_data_i[PIN_COUNT-1:0];
      end
      if (s1_valid_q && advance) begin
        mode_q  <= mode_d;
        otype_q <= otype_d;
        speed_q <= speed_d;
        pull_q  <= pull_d;
        odr_q   <= odr_d;
        afl_q   <= afl_d;
        afh_q   <= afh_d;
        idr_q   <= idr_d;
        alt_q   <= alt_d;
        hist_q  <= hist_d;
        lock_q  <= lock_d;
        dir_q   <= dir_d;
        high_q  <= high_d;
        drive_q <= drive_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= in_data_i;
    end
    if (s1_valid_q && advance) begin
      out_q <= out_d;
    end
  end

endmodule

// ----- sim/gpio_port_register_block_tb.sv -----
module gpio_port_register_block_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gpio_prb_pkg::*;

  localparam int          PINS        = 16;
  localparam logic [15:0] PIN_MASK    = 16'hffff;
  localparam int          LATENCY     = 4;       // two-stage pipe plus margin
  localparam int          CYCLE_LIMIT = 300000;
  localparam int          PRINT_LIMIT = 60;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  gpio_prb_in_t  in_data_i;
  logic          out_valid_o;
  logic          out_ready_i;
  gpio_prb_out_t out_data_o;
  logic          cfg_valid_i;
  logic          cfg_ready_o;
  gpio_prb_cfg_t cfg_data_i;

  gpio_port_register_block #(
    .PIN_COUNT(PINS)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Port model: a shadow copy of every register plus the resolved pin status.
  // It is advanced once per accepted item, in acceptance order, and each call
  // pushes the status item the block must return for that input item.
  // ---------------------------------------------------------------------------
  logic [31:0] port_mode, port_otype, port_speed, port_pull;
  logic [31:0] port_idr, port_odr, port_afl, port_afh;
  logic [31:0] port_lock_hist [3];
  logic        port_locked;
  logic [15:0] port_alt;
  logic [31:0] port_dir;
  logic [15:0] port_high, port_drive, port_changed;
  logic [15:0] port_ext_mask;

  gpio_prb_out_t pending_port_status [$];

  int  mismatch_count;
  int  cycle_count;
  int  stall_left;        // long receiver hold-off, consumed by the receiver
  bit  send_gaps;         // random idle cycles on the input side
  bit  ready_gaps;        // random stall cycles on the output side

  // Resolve one pin from mode, output type, pull and the level it would drive.
  function automatic void resolve_pin(input int p);
    logic [1:0] md, pl, dir;
    logic       lvl, hi, drv, pull_ok;
    md      = port_mode[2*p +: 2];
    pl      = port_pull[2*p +: 2];
    pull_ok = (pl == PULL_NONE) || (pl == PULL_UP);
    dir     = DIR_INPUT;
    hi      = 1'b0;
    drv     = 1'b0;
    case (md)
      MODE_INPUT: begin
        hi = pull_ok;
      end
      MODE_ANALOG: begin
        dir = DIR_HIZ;
      end
      default: begin
        dir = DIR_OUTPUT;
        lvl = (md == MODE_OUTPUT) ? port_odr[p] : port_alt[p];
        if (lvl) begin
          if (!port_otype[p]) begin
            hi  = 1'b1;
            drv = 1'b1;
          end else begin
            hi = pull_ok;   // open drain only floats high when not pulled down
          end
        end
      end
    endcase
    // high pins loop back into idr unless an external circuit owns them
    if (hi && !port_ext_mask[p]) port_idr[p] = 1'b1;
    if (port_dir[2*p +: 2] != dir || port_high[p] != hi || port_drive[p] != drv) begin
      port_dir[2*p +: 2] = dir;
      port_high[p]       = hi;
      port_drive[p]      = drv;
      port_changed[p]    = 1'b1;
    end
  endfunction

  function automatic logic [31:0] read_word(input logic [7:0] a);
    case (a)
      ADDR_MODE:  return port_mode;
      ADDR_OTYPE: return port_otype;
      ADDR_SPEED: return port_speed;
      ADDR_PULL:  return port_pull;
      ADDR_IDR:   return port_idr;
      ADDR_ODR:   return port_odr;
      ADDR_AFL:   return port_afl;
      ADDR_AFH:   return port_afh;
      default:    return 32'h0;   // bsrr, lock and unmapped words
    endcase
  endfunction

  function automatic void bus_write(input logic [7:0] a, input logic [31:0] v);
    logic [31:0] nv;
    logic        hit;
    if (port_locked) return;
    hit = 1'b0;
    case (a)
      ADDR_MODE: begin
        hit = port_mode != v;
        port_mode = v;
      end
      ADDR_OTYPE: begin
        hit = port_otype != v;
        port_otype = v;
      end
      ADDR_SPEED: begin
        hit = port_speed != v;
        port_speed = v;
      end
      ADDR_PULL: begin
        hit = port_pull != v;
        port_pull = v;
      end
      ADDR_ODR: begin
        hit = port_odr != v;
        port_odr = v;
      end
      ADDR_BSRR: begin
        // reset half beats set half
        nv  = (port_odr | {16'h0000, v[15:0]}) & ~{16'h0000, v[31:16]};
        hit = port_odr != nv;
        port_odr = nv;
      end
      ADDR_LOCK: begin
        port_lock_hist[2] = port_lock_hist[1];
        port_lock_hist[1] = port_lock_hist[0];
        port_lock_hist[0] = v;
        if (port_lock_hist[2][LOCK_KEY_BIT] && !port_lock_hist[1][LOCK_KEY_BIT] &&
            port_lock_hist[0][LOCK_KEY_BIT] &&
            port_lock_hist[2][15:0] == port_lock_hist[1][15:0] &&
            port_lock_hist[2][15:0] == port_lock_hist[0][15:0])
          port_locked = 1'b1;
      end
      ADDR_AFL: begin
        hit = port_afl != v;
        port_afl = v;
      end
      ADDR_AFH: begin
        hit = port_afh != v;
        port_afh = v;
      end
      default: ;   // idr and unmapped words drop writes
    endcase
    if (hit) begin
      for (int p = 0; p < PINS; p++) resolve_pin(p);
    end
  endfunction

  function automatic void compute_port_status(input gpio_prb_in_t it);
    gpio_prb_out_t res;
    logic [15:0]   diff;
    res          = '0;
    port_changed = '0;
    case (it.func)
      FUNC_READ: begin
        res.read_data = read_word(it.addr);
      end
      FUNC_WRITE: begin
        bus_write(it.addr, it.wdata);
      end
      FUNC_PIN: begin
        // pin events bypass the external circuit mask and resolve nothing
        if (int'(it.pin_index) < PINS) port_idr[it.pin_index] = it.pin_level;
      end
      default: begin
        diff     = (it.af_levels ^ port_alt) & PIN_MASK;
        port_alt = it.af_levels;
        for (int p = 0; p < PINS; p++) begin
          if (diff[p]) resolve_pin(p);
        end
      end
    endcase
    res.pin_direction = port_dir;
    res.pin_high      = port_high;
    res.pin_drive     = port_drive;
    res.changed_pins  = port_changed;
    res.locked        = port_locked;
    pending_port_status.push_back(res);
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders. Fields that the function ignores carry random values.
  // ---------------------------------------------------------------------------
  function automatic gpio_prb_in_t noise_item();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[$bits(gpio_prb_in_t)-1:0];
  endfunction

  function automatic gpio_prb_in_t rd_item(input logic [7:0] a);
    gpio_prb_in_t it;
    it      = noise_item();
    it.func = FUNC_READ;
    it.addr = a;
    return it;
  endfunction

  function automatic gpio_prb_in_t wr_item(input logic [7:0] a, input logic [31:0] d);
    gpio_prb_in_t it;
    it       = noise_item();
    it.func  = FUNC_WRITE;
    it.addr  = a;
    it.wdata = d;
    return it;
  endfunction

  function automatic gpio_prb_in_t pin_item(input logic [3:0] idx, input logic lvl);
    gpio_prb_in_t it;
    it           = noise_item();
    it.func      = FUNC_PIN;
    it.pin_index = idx;
    it.pin_level = lvl;
    return it;
  endfunction

  function automatic gpio_prb_in_t alt_item(input logic [15:0] af);
    gpio_prb_in_t it;
    it           = noise_item();
    it.func      = FUNC_ALT;
    it.af_levels = af;
    return it;
  endfunction

  // Mostly mapped registers, some rewrites of the value already held, the
  // odd wild address, and alternate levels that often flip a single pin.
  function automatic gpio_prb_in_t random_item();
    gpio_prb_in_t it;
    int unsigned  pick;
    it   = noise_item();
    pick = $urandom_range(99);
    if (pick < 65) begin
      it.func = (pick < 20) ? FUNC_READ : FUNC_WRITE;
      if ($urandom_range(9) != 0) it.addr = 8'($urandom_range(int'(ADDR_AFH)));
      if (it.func == FUNC_WRITE && $urandom_range(3) == 0) it.wdata = read_word(it.addr);
    end else if (pick < 80) begin
      it.func = FUNC_PIN;
    end else begin
      it.func = FUNC_ALT;
      if ($urandom_range(1) == 0) it.af_levels = port_alt ^ (16'h1 << $urandom_range(15));
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset, cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items outstanding", cycle_count,
               pending_port_status.size());
      $display("gpio_port_register_block verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: ready toggles at random, or holds low for a counted stretch.
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= !(ready_gaps && $urandom_range(99) < 28);
      end
    end
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("%0t: %s mismatch: got %h expected %h", $realtime, what, got, want);
  endtask

  // Each returned status item is checked against the oldest prediction.
  always @(posedge clk_i) begin : check_status
    gpio_prb_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_port_status.size() == 0) begin
        flag_mismatch("unexpected item", 32'h0, 32'h0);
      end else begin
        want = pending_port_status.pop_front();
        if (out_data_o.read_data != want.read_data)
          flag_mismatch("read_data", out_data_o.read_data, want.read_data);
        if (out_data_o.pin_direction != want.pin_direction)
          flag_mismatch("pin_direction", out_data_o.pin_direction, want.pin_direction);
        if (out_data_o.pin_high != want.pin_high)
          flag_mismatch("pin_high", 32'(out_data_o.pin_high), 32'(want.pin_high));
        if (out_data_o.pin_drive != want.pin_drive)
          flag_mismatch("pin_drive", 32'(out_data_o.pin_drive), 32'(want.pin_drive));
        if (out_data_o.changed_pins != want.changed_pins)
          flag_mismatch("changed_pins", 32'(out_data_o.changed_pins),
                        32'(want.changed_pins));
        if (out_data_o.locked != want.locked)
          flag_mismatch("locked", 32'(out_data_o.locked), 32'(want.locked));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side. Valid only drops during a random gap, so it never falls and
  // rises within one step; prediction happens at the accepting edge.
  // ---------------------------------------------------------------------------
  task automatic send_item(input gpio_prb_in_t it);
    @(negedge clk_i);
    while (send_gaps && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    compute_port_status(it);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_item(random_item());
  endtask

  // Stop offering items and let every outstanding status item drain.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_port_status.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  // Only called with the pipe empty.
  task automatic write_ext_mask(input logic [15:0] mask);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mask;
    do @(posedge clk_i); while (!cfg_ready_o);
    port_ext_mask = mask;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_reads();
    for (int a = int'(ADDR_MODE); a <= int'(ADDR_AFH); a++) send_item(rd_item(8'(a)));
    send_item(rd_item(8'hff));
  endtask

  // One of each operation, mode and special case, with field extremes.
  task automatic test_directed_ops();
    send_item(wr_item(ADDR_MODE, 32'h5555_5555));    // all push-pull outputs
    send_item(wr_item(ADDR_ODR, 32'h0000_ffff));
    send_item(wr_item(ADDR_ODR, 32'h0000_ffff));     // same value, no resolve
    send_item(wr_item(ADDR_OTYPE, 32'h0000_ffff));   // open drain
    send_item(wr_item(ADDR_PULL, 32'hffff_ffff));    // pulled down, drops high
    send_item(wr_item(ADDR_BSRR, 32'hffff_ffff));    // reset wins over set
    send_item(wr_item(ADDR_BSRR, 32'h0000_a5a5));
    send_item(wr_item(ADDR_IDR, 32'hffff_ffff));     // idr write dropped
    send_item(rd_item(ADDR_IDR));
    send_item(wr_item(ADDR_MODE, 32'haaaa_aaaa));    // alternate function
    send_item(alt_item(16'hffff));
    send_item(alt_item(16'h0000));
    send_item(alt_item(16'h5a5a));
    send_item(wr_item(ADDR_AFL, 32'hffff_ffff));
    send_item(wr_item(ADDR_AFH, 32'h1234_5678));
    send_item(wr_item(ADDR_SPEED, 32'hffff_ffff));
    send_item(wr_item(ADDR_MODE, 32'hffff_ffff));    // high impedance
    send_item(wr_item(ADDR_MODE, 32'h0000_0000));    // back to input
    send_item(wr_item(ADDR_PULL, 32'h0000_0000));
    send_item(pin_item(4'd0, 1'b0));
    send_item(pin_item(4'd15, 1'b1));
    send_item(pin_item(4'd15, 1'b0));
    send_item(wr_item(8'hff, 32'hffff_ffff));        // unmapped word
    send_item(rd_item(ADDR_ODR));
    send_item(rd_item(ADDR_MODE));
  endtask

  // Random traffic under several external circuit masks, extremes included.
  task automatic test_ext_mask_settings();
    logic [15:0] masks [3];
    masks[0] = 16'hffff;
    masks[1] = 16'($urandom());
    masks[2] = 16'h0000;
    foreach (masks[i]) begin
      settle();
      write_ext_mask(masks[i]);
      send_random(100);
    end
  endtask

  // Bulk random traffic; the middle stretch runs with no gaps either side.
  task automatic test_random_traffic();
    send_random(150);
    send_gaps  = 1'b0;
    ready_gaps = 1'b0;
    send_random(150);
    send_gaps  = 1'b1;
    ready_gaps = 1'b1;
    send_random(150);
  endtask

  // Receiver holds off long enough that the pipe fills and in_ready drops.
  task automatic test_output_backpressure();
    send_gaps  = 1'b0;
    stall_left = 60;
    send_random(40);
    send_gaps  = 1'b1;
  endtask

  // Broken key sequences first, then a good one; afterwards all writes drop.
  task automatic test_lock_sequence();
    send_item(wr_item(ADDR_LOCK, 32'h0001_1234));
    send_item(wr_item(ADDR_LOCK, 32'h0000_1234));
    send_item(wr_item(ADDR_LOCK, 32'h0001_4321));   // key values differ
    send_item(wr_item(ADDR_LOCK, 32'h0001_abcd));
    send_item(wr_item(ADDR_LOCK, 32'h0001_abcd));
    send_item(wr_item(ADDR_LOCK, 32'h0001_abcd));   // key bit never cleared
    send_item(rd_item(ADDR_LOCK));
    // upper bits other than the key bit do not matter
    send_item(wr_item(ADDR_LOCK, 32'h0001_beef));
    send_item(wr_item(ADDR_LOCK, 32'hfffe_beef));
    send_item(wr_item(ADDR_LOCK, 32'h0003_beef));
    send_item(wr_item(ADDR_MODE, 32'h5555_5555));
    send_item(wr_item(ADDR_BSRR, 32'h0000_ffff));
    send_item(wr_item(ADDR_LOCK, 32'h0000_0000));
    send_item(rd_item(ADDR_MODE));
    send_item(pin_item(4'd7, 1'b1));
    send_item(alt_item(16'h0f0f));
    settle();
    write_ext_mask(16'h00ff);
    send_random(40);
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    out_ready_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    send_gaps      = 1'b1;
    ready_gaps     = 1'b1;
    stall_left     = 0;
    mismatch_count = 0;
    cycle_count    = 0;

    port_mode = '0; port_otype = '0; port_speed = '0; port_pull = '0;
    port_idr = '0; port_odr = '0; port_afl = '0; port_afh = '0;
    foreach (port_lock_hist[i]) port_lock_hist[i] = '0;
    port_locked   = 1'b0;
    port_alt      = '0;
    port_dir      = '0;
    port_high     = '0;
    port_drive    = '0;
    port_changed  = '0;
    port_ext_mask = '0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_ext_mask(16'h0000);
    test_reset_reads();
    test_directed_ops();
    test_ext_mask_settings();
    test_random_traffic();
    test_output_backpressure();
    test_lock_sequence();
    settle();

    if (mismatch_count == 0) begin
      $display("gpio_port_register_block verification clean");
    end else begin
      $display("gpio_port_register_block verification failed");
    end
    $finish;
  end

endmodule
